/* hw/rtl/table_linear_interpolation_unit_macros.svh */
// Assertion macros shared by the table interpolation RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TABLE_LINEAR_INTERPOLATION_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATION_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TLI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tli: same-cycle check failed");
`define TLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");
`else
`define TLI_ASSERT_IMPL(label, ante, cons)
`define TLI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/tli_pkg.sv */
// Shared constants and types of the table interpolation unit.
// No dependencies; used by the channel interfaces, the divider and the top level.
package tli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PTS_W       = 11;
    localparam int DATA_W      = 32;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int QUO_W       = 41;
    localparam int HEAD_W      = PROD_W - QUO_W;
    localparam int SUM_W       = QUO_W + 1;

    localparam logic [QUO_W-1:0] QUO_CAP   = {1'b1, {(QUO_W-1){1'b0}}};
    localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(2);
    localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(TABLE_DEPTH);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } tli_div_stat_t;

endpackage

/* hw/rtl/tli_ifs.sv */
// Valid/ready channel interfaces of the table interpolation unit.
// Depends on tli_pkg for the field widths.
interface tli_req_if import tli_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;

    modport source (output valid, cmd, point_index, point_x, point_y, query_x, input ready);
    modport sink   (input valid, cmd, point_index, point_x, point_y, query_x, output ready);
endinterface

interface tli_rsp_if import tli_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_y;
    logic                     status;

    modport source (output valid, result_y, status, input ready);
    modport sink   (input valid, result_y, status, output ready);
endinterface

interface tli_cfg_if import tli_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PTS_W-1:0] points_in_use;

    modport source (output valid, points_in_use, input ready);
    modport sink   (input valid, points_in_use, output ready);
endinterface

/* hw/rtl/tli_div.sv */
// Restoring divider, one quotient bit per cycle, with the quotient capped at 2^40.
// Depends on tli_pkg.
module tli_div import tli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [MAG_W-1:0]  divisor,
    output logic [QUO_W-1:0]  quotient,
    output tli_div_stat_t     stat
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  dvd_reg, dvd_next;
    logic [MAG_W-1:0]  dvs_reg, dvs_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;

    logic [MAG_W-1:0]  head;
    logic [MAG_W:0]    trial;
    logic [MAG_W:0]    diff;
    logic              fits;

    // A head at or above the divisor means the true quotient is at least 2^41.
    assign head  = {{(MAG_W-HEAD_W){1'b0}}, dividend[PROD_W-1:QUO_W]};
    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            dvs_next = divisor;
            if (head >= divisor)
            begin
                quo_next  = QUO_CAP;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = head;
                dvd_next  = dividend[QUO_W-1:0];
                quo_next  = '0;
                cnt_next  = STEP_W'(QUO_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            dvd_next = {dvd_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient  = (quo_reg > QUO_CAP) ? QUO_CAP : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hw/rtl/table_linear_interpolation_unit.sv */
// Piecewise-linear table interpolation unit, signed Q16.16, sequential.
// A load request writes its point as it is accepted. A query request, from acceptance
// to result, reads the table ends, runs a binary search (up to 11 probes, one table
// memory read each), reads the bracket, multiplies, and runs the bit-serial divider,
// which takes most of the time.
// Reset (rst_n, asynchronous, active low) clears control state and sets points_in_use to 2.
`include "table_linear_interpolation_unit_macros.svh"

module table_linear_interpolation_unit import tli_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tli_req_if.sink   req,
    tli_rsp_if.source rsp,
    tli_cfg_if.sink   cfg
);

    // Query sequencer. Every state that reads the table issues the address in
    // that cycle; the data turns up in rd_data_reg in the following state.
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_RD_FIRST = 14'b00000000000010,
        S_RD_LAST  = 14'b00000000000100,
        S_CHECK    = 14'b00000000001000,
        S_PROBE    = 14'b00000000010000,
        S_COMPARE  = 14'b00000000100000,
        S_BRACKET  = 14'b00000001000000,
        S_RD_UPPER = 14'b00000010000000,
        S_DIFF     = 14'b00000100000000,
        S_MUL      = 14'b00001000000000,
        S_DIV_GO   = 14'b00010000000000,
        S_DIV_WAIT = 14'b00100000000000,
        S_FINAL    = 14'b01000000000000,
        S_EMIT     = 14'b10000000000000
    } state_t;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(33'sh0_8000_0000);

    state_t state_reg, state_next;

    // The table: abscissa in the upper half of each word, value in the lower half.
    logic [2*DATA_W-1:0] point_mem [TABLE_DEPTH];
    logic [2*DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_en;
    logic                wr_en;

    logic [PTS_W-1:0]  pts_reg, pts_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  n_calc;
    logic signed [DATA_W-1:0] xq_reg, xq_next;
    logic signed [DATA_W-1:0] xfirst_reg, xfirst_next;
    logic signed [CNT_W:0]    lo_reg, lo_next;
    logic signed [CNT_W:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic [IDX_W-1:0]  idx0_reg, idx0_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next;
    logic [MAG_W-1:0]  mdy_reg, mdy_next;
    logic [MAG_W-1:0]  mdq_reg, mdq_next;
    logic [MAG_W-1:0]  mdx_reg, mdx_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic signed [DATA_W-1:0] res_y_reg, res_y_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_y_reg, out_y_next;
    logic              out_status_reg, out_status_next;

    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic signed [CNT_W:0]    span;
    logic signed [CNT_W:0]    mid_wide;
    logic signed [CNT_W:0]    mid_s;
    logic signed [CNT_W:0]    n_m2;
    logic signed [CNT_W:0]    idx0_wide;
    logic [CNT_W-1:0]         last_idx;
    logic signed [MAG_W:0]    dy, dq, dx;
    logic signed [MAG_W:0]    ady, adq, adx;
    logic signed [SUM_W-1:0]  sum;
    logic                     slot_free;
    logic                     div_start;
    logic [QUO_W-1:0]         div_quo;
    tli_div_stat_t            div_stat;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign wr_en     = req.valid && req.ready && (req.cmd == CMD_LOAD);

    assign rsp.valid    = out_valid_reg;
    assign rsp.result_y = out_y_reg;
    assign rsp.status   = out_status_reg;

    assign rd_x = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_y = rd_data_reg[DATA_W-1:0];

    // The point count used by a query is held within 2 and the table depth.
    assign n_calc = (CNT_W'(pts_reg) < CNT_MIN) ? CNT_MIN :
                    (CNT_W'(pts_reg) > CNT_MAX) ? CNT_MAX : CNT_W'(pts_reg);
    assign last_idx = n_reg - CNT_W'(1);

    // Binary-search midpoint; the search span is never negative while probing.
    assign span     = hi_reg - lo_reg;
    assign mid_wide = lo_reg + (span >>> 1);
    assign mid_s    = $signed({{(CNT_W+1-IDX_W){1'b0}}, mid_reg});

    // Lower bracket index, held within 0 .. count-2 for tables that do not increase.
    assign n_m2      = $signed({1'b0, n_reg}) - (CNT_W+1)'(2);
    assign idx0_wide = (hi_reg < 0) ? '0 : ((hi_reg > n_m2) ? n_m2 : hi_reg);

    // Differences of two 32-bit values always have magnitudes that fit in 32 bits.
    assign dy  = {rd_y[DATA_W-1], rd_y} - {y0_reg[DATA_W-1], y0_reg};
    assign dq  = {xq_reg[DATA_W-1], xq_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dx  = {rd_x[DATA_W-1], rd_x} - {x0_reg[DATA_W-1], x0_reg};
    assign ady = dy[MAG_W] ? -dy : dy;
    assign adq = dq[MAG_W] ? -dq : dq;
    assign adx = dx[MAG_W] ? -dx : dx;

    assign sum = neg_reg ? (SUM_W'(y0_reg) - $signed({1'b0, q_reg}))
                         : (SUM_W'(y0_reg) + $signed({1'b0, q_reg}));

    assign slot_free = !out_valid_reg || rsp.ready;
    assign div_start = (state_reg == S_DIV_GO);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_RD_FIRST:
            begin
                rd_en = 1'b1;
            end
            S_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = last_idx[IDX_W-1:0];
            end
            S_PROBE:
            begin
                rd_en   = 1'b1;
                rd_addr = mid_wide[IDX_W-1:0];
            end
            S_BRACKET:
            begin
                rd_en   = 1'b1;
                rd_addr = idx0_wide[IDX_W-1:0];
            end
            S_RD_UPPER:
            begin
                rd_en   = 1'b1;
                rd_addr = idx0_reg + IDX_W'(1);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        pts_next        = pts_reg;
        n_next          = n_reg;
        xq_next         = xq_reg;
        xfirst_next     = xfirst_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx0_next       = idx0_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        mdy_next        = mdy_reg;
        mdq_next        = mdq_reg;
        mdx_next        = mdx_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        q_next          = q_reg;
        res_y_next      = res_y_reg;
        res_status_next = res_status_reg;
        out_y_next      = out_y_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        if (cfg.valid)
        begin
            pts_next = cfg.points_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && (req.cmd == CMD_QUERY))
                begin
                    xq_next    = req.query_x;
                    n_next     = n_calc;
                    state_next = S_RD_FIRST;
                end
            end
            S_RD_FIRST:
            begin
                state_next = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                xfirst_next = rd_x;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                // The last point's entry is on the read port now.
                if ((xq_reg < xfirst_reg) || (xq_reg > rd_x))
                begin
                    res_y_next      = '0;
                    res_status_next = STATUS_RANGE;
                    state_next      = S_EMIT;
                end
                else if (xq_reg == rd_x)
                begin
                    res_y_next      = rd_y;
                    res_status_next = STATUS_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = $signed({1'b0, last_idx});
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                mid_next   = mid_wide[IDX_W-1:0];
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (rd_x == xq_reg)
                begin
                    res_y_next      = rd_y;
                    res_status_next = STATUS_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    if (rd_x > xq_reg)
                    begin
                        hi_next = mid_s - (CNT_W+1)'(1);
                    end
                    else
                    begin
                        lo_next = mid_s + (CNT_W+1)'(1);
                    end
                    state_next = (hi_next >= lo_next) ? S_PROBE : S_BRACKET;
                end
            end
            S_BRACKET:
            begin
                idx0_next  = idx0_wide[IDX_W-1:0];
                state_next = S_RD_UPPER;
            end
            S_RD_UPPER:
            begin
                x0_next    = rd_x;
                y0_next    = rd_y;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                // A zero span answers the lower value unchanged.
                if (dx == '0)
                begin
                    res_y_next      = y0_reg;
                    res_status_next = STATUS_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    mdy_next   = ady[MAG_W-1:0];
                    mdq_next   = adq[MAG_W-1:0];
                    mdx_next   = adx[MAG_W-1:0];
                    neg_next   = dy[MAG_W] ^ dq[MAG_W] ^ dx[MAG_W];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mdy_reg * mdq_reg;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    q_next     = div_quo;
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (sum > SAT_MAX)
                begin
                    res_y_next = SAT_MAX[DATA_W-1:0];
                end
                else if (sum < SAT_MIN)
                begin
                    res_y_next = SAT_MIN[DATA_W-1:0];
                end
                else
                begin
                    res_y_next = sum[DATA_W-1:0];
                end
                res_status_next = STATUS_OK;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                // Wait here only while the previous result is still unclaimed.
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_y_next      = res_y_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tli_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mdx_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Table memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[req.point_index] <= {req.point_x, req.point_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= point_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pts_reg       <= PTS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pts_reg       <= pts_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        xq_reg         <= xq_next;
        xfirst_reg     <= xfirst_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx0_reg       <= idx0_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        mdy_reg        <= mdy_next;
        mdq_reg        <= mdq_next;
        mdx_reg        <= mdx_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        q_reg          <= q_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
    end

    `TLI_ASSERT_IMPL(a_probe_span, state_reg == S_PROBE, (lo_reg <= hi_reg) && (hi_reg < $signed({1'b0, n_reg})))
    `TLI_ASSERT_IMPL(a_bracket_range, state_reg == S_RD_UPPER, (CNT_W'(idx0_reg) + CNT_W'(2)) <= n_reg)
    `TLI_ASSERT_IMPL(a_range_zero, out_valid_reg && (out_status_reg == STATUS_RANGE), out_y_reg == '0)
    `TLI_ASSERT_IMPL(a_div_idle_start, div_start, !div_stat.busy)
    `TLI_ASSERT_NEXT(a_emit_lands, (state_reg == S_EMIT) && slot_free, out_valid_reg && (state_reg == S_IDLE))

endmodule

/* tb/tli_answer_checker.sv */
// Answer checker for the table interpolation unit: follows the configuration and
// request channels, predicts every query answer and compares it with the response channel.
// Depends on tli_pkg and on the channel interfaces in tli_ifs.sv.
module tli_answer_checker import tli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tli_req_if   req,
    tli_rsp_if   rsp,
    tli_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_y;
        logic                     status;
    } answer_t;

    logic signed [DATA_W-1:0] abscissa_tab [TABLE_DEPTH];
    logic signed [DATA_W-1:0] value_tab    [TABLE_DEPTH];
    logic [PTS_W-1:0]         points_cfg;
    answer_t                  answers_due [$];

    // Answer to one query against the current table and point count.
    function automatic answer_t answer_query(logic signed [DATA_W-1:0] query);
        int           count;
        int           lo;
        int           hi;
        int           mid;
        int           base;
        longint       xq;
        longint       xm;
        longint       x0;
        longint       x1;
        longint       y0;
        longint       y1;
        longint       dy;
        longint       dq;
        longint       dx;
        longint       step;
        longint       value;
        bit           hit;
        bit           negate;
        logic [127:0] product;
        logic [127:0] quotient;
        answer_t      ans;

        count = int'(points_cfg);
        if (count < 2)
            count = 2;
        if (count > TABLE_DEPTH)
            count = TABLE_DEPTH;

        xq         = longint'(query);
        ans.status = STATUS_OK;
        if (xq < longint'(abscissa_tab[0]) || xq > longint'(abscissa_tab[count-1]))
        begin
            ans.result_y = '0;
            ans.status   = STATUS_RANGE;
            return ans;
        end
        if (xq == longint'(abscissa_tab[count-1]))
        begin
            ans.result_y = value_tab[count-1];
            return ans;
        end

        lo   = 0;
        hi   = count - 1;
        base = 0;
        hit  = 1'b0;
        while (hi >= lo && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            xm  = longint'(abscissa_tab[mid]);
            if (xm > xq)
                hi = mid - 1;
            else if (xm < xq)
                lo = mid + 1;
            else
            begin
                base = mid;
                hit  = 1'b1;
            end
        end
        if (hit)
        begin
            ans.result_y = value_tab[base];
            return ans;
        end

        // The lower bracket is kept inside the table even when it is not increasing.
        base = hi;
        if (base < 0)
            base = 0;
        if (base > count - 2)
            base = count - 2;
        x0 = longint'(abscissa_tab[base]);
        x1 = longint'(abscissa_tab[base+1]);
        y0 = longint'(value_tab[base]);
        y1 = longint'(value_tab[base+1]);
        dx = x1 - x0;
        if (dx == 0)
            value = y0;
        else
        begin
            dy       = y1 - y0;
            dq       = xq - x0;
            negate   = (dy < 0) ^ (dq < 0) ^ (dx < 0);
            product  = 128'(dy < 0 ? -dy : dy) * 128'(dq < 0 ? -dq : dq);
            quotient = product / 128'(dx < 0 ? -dx : dx);
            if (quotient > 128'(QUO_CAP))
                quotient = 128'(QUO_CAP);
            step  = longint'(quotient[63:0]);
            value = negate ? y0 - step : y0 + step;
            if (value > 64'sd2147483647)
                value = 64'sd2147483647;
            if (value < -64'sd2147483648)
                value = -64'sd2147483648;
        end
        ans.result_y = value[DATA_W-1:0];
        return ans;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        points_cfg = PTS_RESET;
    end

    always @(posedge clk or negedge rst_n)
    begin : follow_channels
        answer_t due;
        if (!rst_n)
        begin
            points_cfg = PTS_RESET;
            answers_due.delete();
        end
        else
        begin
            if ((rsp.valid & rsp.ready) === 1'b1)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result_y: expected no result, got %0d (status %0d)",
                           rsp.result_y, rsp.status);
                    fail_count++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (rsp.result_y !== due.result_y)
                    begin
                        $error("result_y: expected %0d, got %0d", due.result_y, rsp.result_y);
                        fail_count++;
                    end
                    if (rsp.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if ((cfg.valid & cfg.ready) === 1'b1)
                points_cfg = cfg.points_in_use;
            if ((req.valid & req.ready) === 1'b1)
            begin
                if (req.cmd == CMD_LOAD)
                begin
                    abscissa_tab[req.point_index] = req.point_x;
                    value_tab[req.point_index]    = req.point_y;
                end
                else
                    answers_due.push_back(answer_query(req.query_x));
            end
        end
        pending = answers_due.size();
    end

endmodule

/* tb/tb_table_linear_interpolation_unit.sv */
// Top level of the table interpolation unit testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Prediction lives in tli_answer_checker.
// Depends on tli_pkg, the channel interfaces and the table_linear_interpolation_unit RTL.
module tb_table_linear_interpolation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tli_pkg::*;

    // Longest stretch without any accepted request, response or register write before
    // the run is declared hung. The slowest legitimate quiet stretch is the long
    // response hold-off plus one query latency.
    localparam int QUIET_LIMIT    = 4000;
    // Length of the deliberate response hold-off that fills the unit up.
    localparam int SQUEEZE_CYCLES = 600;
    // Settling time that covers anything still in flight.
    localparam int SETTLE_CYCLES  = 100;
    // Requests of either kind to send in all, directed ones included.
    localparam int ITEM_TARGET    = 650;

    localparam longint X_MIN = -64'sd2147483648;
    localparam longint X_MAX = 64'sd2147483647;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    // How the abscissae of a freshly loaded table are laid out.
    typedef enum int {
        SHAPE_WIDE,      // increasing, random steps up to an even share of the whole signed range
        SHAPE_NARROW,    // increasing, random step sizes
        SHAPE_TIGHT,     // increasing by one to three LSBs
        SHAPE_SCRAMBLED  // arbitrary order with repeated abscissae
    } shape_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int  fail_count;
    int  pending;
    int  quiet_cycles = 0;
    int  sent_count   = 0;
    int  active_count = 2;
    bit  no_idle      = 1'b0;
    bit  squeeze_req  = 1'b0;

    // Abscissae as the stimulus loaded them, used to aim queries at the table.
    logic signed [DATA_W-1:0] table_x [TABLE_DEPTH];

    tli_req_if req_ch ();
    tli_rsp_if rsp_ch ();
    tli_cfg_if cfg_ch ();

    table_linear_interpolation_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tli_answer_checker answer_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // The watchdog only counts cycles in which nothing at all moves, so long runs are
    // never cut short, whereas a unit that has locked up is caught quickly.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid & req_ch.ready) === 1'b1 ||
                (rsp_ch.valid & rsp_ch.ready) === 1'b1 ||
                (cfg_ch.valid & cfg_ch.ready) === 1'b1)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic longint random_in(input longint lo, input longint hi);
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return lo + longint'(raw % 64'(hi - lo + 1));
    endfunction

    // The unit treats counts below two as two and above the depth as the depth.
    function automatic int clamp_points(input int setting);
        if (setting < 2)
            return 2;
        if (setting > TABLE_DEPTH)
            return TABLE_DEPTH;
        return setting;
    endfunction

    // Offers one request and returns at the edge at which it is accepted. The caller
    // must, in that same time step, either offer the next request or drop valid, so
    // that valid never gets two nonblocking assignments within one step.
    task automatic send_request(input logic cmd, input logic [IDX_W-1:0] slot,
                                input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                                input logic [DATA_W-1:0] qx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.point_index <= slot;
        req_ch.point_x     <= px;
        req_ch.point_y     <= py;
        req_ch.query_x     <= qx;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
    endtask

    // The query field of a load request and the point fields of a query request carry
    // random values; the unit has to ignore them.
    task automatic load_point(input int slot, input logic [DATA_W-1:0] x,
                              input logic [DATA_W-1:0] y);
        send_request(CMD_LOAD, IDX_W'(slot), x, y, $urandom());
        table_x[slot] = x;
    endtask

    task automatic query(input logic [DATA_W-1:0] x);
        send_request(CMD_QUERY, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                     $urandom(), $urandom(), x);
    endtask

    // The register may only change while the unit is idle: every answer must have come
    // back and a trailing load request must have had time to complete. The extra edge
    // lets the checker count a query accepted at the edge on which this task starts.
    task automatic write_points(input int setting);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.points_in_use <= PTS_W'(setting);
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        active_count = clamp_points(setting);
    endtask

    // Loads slots 0 to n-1 with a fresh table of the given shape.
    task automatic load_table(input int n, input shape_t shape);
        longint quota;
        longint max_step;
        longint room;
        longint x;
        int     roll;
        logic [DATA_W-1:0] y;

        quota = (X_MAX - X_MIN) / n;
        case (shape)
            SHAPE_WIDE:   max_step = quota;
            SHAPE_TIGHT:  max_step = 3;
            default:      max_step = random_in(1, quota);
        endcase
        room = (X_MAX - X_MIN) - longint'(n - 1) * max_step;
        x    = X_MIN + random_in(0, room);
        for (int i = 0; i < n; i++)
        begin
            if (shape == SHAPE_SCRAMBLED)
            begin
                if (i == 0 || $urandom_range(0, 3) != 0)
                    x = random_in(X_MIN, X_MAX);
            end
            else if (i > 0)
                x = x + random_in(1, max_step);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                y = Q_MIN;
            else if (roll == 1)
                y = Q_MAX;
            else
                y = $urandom();
            load_point(i, DATA_W'(x), y);
        end
    endtask

    // One random item of a phase: mostly queries aimed inside the table, at its points
    // and next to them, at its ends and outside them; the rest are stray load requests.
    task automatic random_query();
        longint first;
        longint last;
        longint pick;
        int     roll;
        int     slot;

        first = longint'(table_x[0]);
        last  = longint'(table_x[active_count - 1]);
        slot  = $urandom_range(0, active_count - 1);
        roll  = $urandom_range(0, 99);
        if (roll < 40)
            pick = (first < last) ? random_in(first, last) : random_in(X_MIN, X_MAX);
        else if (roll < 55)
            pick = longint'(table_x[slot]);
        else if (roll < 65)
            pick = longint'(table_x[slot]) + (($urandom_range(0, 1) == 1) ? 1 : -1);
        else if (roll < 72)
            pick = ($urandom_range(0, 1) == 1) ? first : last;
        else if (roll < 80)
            pick = (first > X_MIN) ? random_in(X_MIN, first - 1) : X_MIN;
        else if (roll < 86)
            pick = (last < X_MAX) ? random_in(last + 1, X_MAX) : X_MAX;
        else if (roll < 92)
            pick = random_in(X_MIN, X_MAX);
        else
        begin
            // A stray load inside the table keeps its abscissa so that the table keeps
            // its shape; one beyond it may write anything.
            slot = $urandom_range(0, TABLE_DEPTH - 1);
            if (slot < active_count)
                load_point(slot, table_x[slot], $urandom());
            else
                load_point(slot, $urandom(), $urandom());
            return;
        end
        query(DATA_W'(pick));
    endtask

    // One phase: optionally a fresh table, a register write, then a burst of items.
    // With hold set, the response side stalls for a long stretch while requests keep
    // coming, so that the unit fills up and stops accepting requests.
    task automatic run_phase(input int setting, input bit reload, input int n_items,
                             input bit hold);
        no_idle = ($urandom_range(0, 3) == 0);
        if (reload)
            load_table(clamp_points(setting), shape_t'($urandom_range(0, 3)));
        write_points(setting);
        if (hold)
        begin
            no_idle     = 1'b1;
            squeeze_req = 1'b1;
        end
        repeat (n_items) random_query();
    endtask

    // A count at the depth or above it, with only the first and the highest slot
    // loaded. The queries never reach the search: they fall below the first point,
    // above the highest one, or exactly on the highest one.
    task automatic run_wide_phase(input int setting, input int n_items);
        logic signed [DATA_W-1:0] lo_x;
        logic signed [DATA_W-1:0] hi_x;
        longint                   pick;
        int                       roll;

        no_idle = ($urandom_range(0, 3) == 0);
        lo_x    = DATA_W'(random_in(X_MIN + 1, -1));
        hi_x    = DATA_W'(random_in(0, X_MAX - 1));
        load_point(0, lo_x, $urandom());
        load_point(TABLE_DEPTH - 1, hi_x, $urandom());
        write_points(setting);
        for (int i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(0, 2);
            if (roll == 0)
                pick = random_in(X_MIN, longint'(lo_x) - 1);
            else if (roll == 1)
                pick = random_in(longint'(hi_x) + 1, X_MAX);
            else
                pick = longint'(hi_x);
            query(DATA_W'(pick));
        end
    endtask

    // Response side: random stalls of random length, stretches without any, and the one
    // long hold-off that the stimulus asks for.
    initial
    begin : response_side
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int phase;

        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_LOAD;
        req_ch.point_index   <= '0;
        req_ch.point_x       <= '0;
        req_ch.point_y       <= '0;
        req_ch.query_x       <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.points_in_use <= PTS_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A two-point table spanning the whole signed range with the
        // steepest falling slope: exact hits at both ends and interpolation in between.
        load_point(0, Q_MIN, Q_MAX);
        load_point(1, Q_MAX, Q_MIN);
        write_points(2);
        query(Q_MIN);
        query(Q_MAX);
        query(32'sh0000_0000);
        query(32'shFFFF_FFFF);
        query(32'sh0000_0001);
        // A load to the highest slot; the full-depth phases write it again before use.
        load_point(TABLE_DEPTH - 1, $urandom(), $urandom());

        // A small table from -5.0 to 5.0 rising from 0 to 100.0: queries below and above
        // it, at the extremes of the field, at both ends and at an interior point.
        load_point(0, 32'shFFFB_0000, 32'sh0000_0000);
        load_point(1, 32'sh0005_0000, 32'sh0064_0000);
        query(32'shFFFA_0000);
        query(32'sh0006_0000);
        query(Q_MIN);
        query(Q_MAX);
        query(32'shFFFB_0000);
        query(32'sh0005_0000);
        query(32'sh0000_8000);

        // Point counts below two behave as two.
        write_points(0);
        query(32'sh0001_0000);
        write_points(1);
        query(32'shFFFF_0000);

        // Random part: mostly small tables, a count at the depth and later above it,
        // and one long response hold-off.
        phase = 0;
        while (sent_count < ITEM_TARGET)
        begin
            phase++;
            if (phase == 3)
                run_phase($urandom_range(4, 16), 1'b1, 30, 1'b1);
            else if (phase == 8)
                run_wide_phase(TABLE_DEPTH, 12);
            else if (phase > 8 && phase % 5 == 0)
                run_wide_phase($urandom_range(TABLE_DEPTH + 1, (1 << PTS_W) - 1), 10);
            else if (phase % 7 == 0)
                run_phase($urandom_range(0, 1), 1'b1, 15, 1'b0);
            else
                run_phase($urandom_range(2, 24), 1'b1, $urandom_range(10, 30), 1'b0);
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/tli_ifs.sv
hw/rtl/tli_div.sv
hw/rtl/table_linear_interpolation_unit.sv
tb/tli_answer_checker.sv
tb/tb_table_linear_interpolation_unit.sv
